// ===== hw/rtl/stbe_pkg.sv =====
// Shared constants, types and fixed-point helpers for the smoothstep trajectory evaluator.
// Depends on nothing; the top level and stbe_div import it.
`timescale 1ns / 1ps

package stbe_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int RATE_FRAC_BITS = 16;
  localparam int DIV_LAT        = 34;
  localparam int CFG_AW         = 3;

  localparam logic [15:0] BLEND_TC_RESET = 16'd256;

  typedef enum logic [0:0] {
    REG_BLEND_TC = 1'b0
  } reg_idx_e;

  typedef logic [31:0] word_t;

  function automatic word_t sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic word_t zext16(logic [15:0] v);
    return {16'b0, v};
  endfunction

  function automatic word_t asr(word_t x, int unsigned n);
    return word_t'($signed(x) >>> n);
  endfunction

  function automatic logic slt(word_t a, word_t b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== hw/rtl/stbe_if.sv =====
// Valid/ready channel interfaces for the trajectory sample and its result.
// Depends on nothing.
`timescale 1ns / 1ps

interface stbe_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] start_position;
  logic signed [15:0] end_position;
  logic signed [15:0] start_velocity;
  logic signed [15:0] end_velocity;
  logic        [15:0] segment_duration;
  logic        [15:0] sample_time;

  modport source (
    output valid, start_position, end_position, start_velocity, end_velocity,
           segment_duration, sample_time,
    input  ready
  );
  modport sink (
    input  valid, start_position, end_position, start_velocity, end_velocity,
           segment_duration, sample_time,
    output ready
  );
endinterface

interface stbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] position;
  logic signed [15:0] velocity;

  modport source (output valid, position, velocity, input ready);
  modport sink (input valid, position, velocity, output ready);
endinterface

// ===== hw/rtl/smoothstep_blended_trajectory_eval.sv =====
// Top level of the smoothstep-blended trajectory sample evaluator.
// Depends on stbe_pkg, stbe_if, stbe_dly and stbe_div.
//
// Usage: one trajectory sample enters as a transaction on in_i (positions,
// velocities, segment duration, sample time); exactly one result transaction
// with position and velocity leaves on out_o, in order. The blend time
// constant is written through the APB port at byte address 0 and reads back
// there; write it only while no sample is in flight.
// A new sample is taken every cycle while out_o does not stall; samples pass
// through two rounds of 34-stage pipelined dividers (window, middle line and
// ramp phases) and register stages for the multiplies of the smoothstep and
// blend math. When out_o stalls, the whole pipeline holds and in_i.ready
// drops in the same cycle, so no transaction is lost or repeated; a bubble at
// the output register lets the pipeline move on. Reset empties the pipeline
// and sets the blend time constant to 256.
`timescale 1ns / 1ps

module smoothstep_blended_trajectory_eval #(
  parameter int FracBits     = stbe_pkg::FRAC_BITS,
  parameter int RateFracBits = stbe_pkg::RATE_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  stbe_in_if.sink                       in_i,
  stbe_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stbe_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import stbe_pkg::*;

  typedef enum logic [1:0] {
    MODE_MID,
    MODE_LEFT,
    MODE_RIGHT,
    MODE_BOTH
  } mode_e;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] av;
    logic [15:0] bv;
    logic [15:0] t;
    logic [15:0] tf;
    word_t       tmt;
    word_t       l;
    word_t       r;
  } sb1_t;

  typedef struct packed {
    logic [15:0] av;
    logic [15:0] bv;
    logic [15:0] t;
    logic [15:0] tf;
    word_t       l;
    word_t       r;
    word_t       m;
    word_t       mp;
    word_t       u2;
  } sb3_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] av;
    logic [15:0] bv;
    word_t       l;
    word_t       r;
    word_t       m;
    word_t       mp;
  } pass_t;

  localparam word_t One      = word_t'(1) << FracBits;
  localparam word_t RateOne  = word_t'(1) << RateFracBits;

  function automatic word_t sabs(word_t x);
    return x[31] ? word_t'(-x) : x;
  endfunction

  function automatic word_t smax(word_t a, word_t b);
    return slt(a, b) ? b : a;
  endfunction

  // Configuration register.
  logic [15:0] alpha_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= BLEND_TC_RESET;
    end else if (cfg_wr && (reg_idx_e'(paddr[2]) == REG_BLEND_TC)) begin
      alpha_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx_e'(paddr[2]) == REG_BLEND_TC) begin
      prdata = zext16(alpha_q);
    end
  end

  // Pipeline control.
  logic en;
  logic v0_q, v1_q, vp_q, v2_q, v3_q, vq_q;
  logic v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, vout_q;

  assign en         = !vout_q || out_o.ready;
  assign in_i.ready = en;

  // Input stage.
  logic [15:0] a0_q, b0_q, av0_q, bv0_q, tf0_q, t0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q  <= in_i.start_position;
      b0_q  <= in_i.end_position;
      av0_q <= in_i.start_velocity;
      bv0_q <= in_i.end_velocity;
      tf0_q <= in_i.segment_duration;
      t0_q  <= in_i.sample_time;
    end
  end

  // Ramps, middle-line products and divider operands.
  word_t a_s1, b_s1, av_s1, bv_s1, t_s1, tf_s1, d_s1;
  sb1_t  sb1_d, sb1_q;
  word_t dt1_q, dsh1_q, tsh1_q;

  always_comb begin
    a_s1  = sext16(a0_q);
    b_s1  = sext16(b0_q);
    av_s1 = sext16(av0_q);
    bv_s1 = sext16(bv0_q);
    t_s1  = zext16(t0_q);
    tf_s1 = zext16(tf0_q);
    d_s1  = b_s1 - a_s1;
    sb1_d.a   = a0_q;
    sb1_d.av  = av0_q;
    sb1_d.bv  = bv0_q;
    sb1_d.t   = t0_q;
    sb1_d.tf  = tf0_q;
    sb1_d.tmt = tf_s1 - t_s1;
    sb1_d.l   = asr(av_s1 * t_s1, FracBits) + a_s1;
    sb1_d.r   = asr(bv_s1 * (t_s1 - tf_s1), FracBits) + b_s1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb1_q  <= sb1_d;
      dt1_q  <= d_s1 * t_s1;
      dsh1_q <= d_s1 << FracBits;
      tsh1_q <= t_s1 << FracBits;
    end
  end

  // First divider round.
  word_t vfloor_p, mq_p, mp_p, u2_p;
  sb1_t  sbp;
  logic  vp_d;

  stbe_div u_div_vfloor (
    .clk_i, .en_i(en), .num_i(RateOne), .den_i(zext16(sb1_q.tf)), .quo_o(vfloor_p)
  );
  stbe_div u_div_mline (
    .clk_i, .en_i(en), .num_i(dt1_q), .den_i(zext16(sb1_q.tf)), .quo_o(mq_p)
  );
  stbe_div u_div_mslope (
    .clk_i, .en_i(en), .num_i(dsh1_q), .den_i(zext16(sb1_q.tf)), .quo_o(mp_p)
  );
  stbe_div u_div_phase (
    .clk_i, .en_i(en), .num_i(tsh1_q), .den_i(zext16(sb1_q.tf)), .quo_o(u2_p)
  );
  stbe_dly #(.Width($bits(sb1_t)), .Depth(DIV_LAT)) u_dly_sb1 (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb1_q), .q_o(sbp)
  );
  stbe_dly #(.Width(1), .Depth(DIV_LAT)) u_dly_v1 (
    .clk_i, .rst_ni, .en_i(en), .d_i(v1_q), .q_o(vp_d)
  );

  assign vp_q = vp_d;

  // Window velocities and middle line.
  sb3_t  sb2_q;
  word_t tmt2_q, avm2_q, bvm2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb2_q.av <= sbp.av;
      sb2_q.bv <= sbp.bv;
      sb2_q.t  <= sbp.t;
      sb2_q.tf <= sbp.tf;
      sb2_q.l  <= sbp.l;
      sb2_q.r  <= sbp.r;
      sb2_q.m  <= mq_p + sext16(sbp.a);
      sb2_q.mp <= mp_p;
      sb2_q.u2 <= u2_p;
      tmt2_q   <= sbp.tmt;
      avm2_q   <= smax(sabs(sext16(sbp.av)), vfloor_p);
      bvm2_q   <= smax(sabs(sext16(sbp.bv)), vfloor_p);
    end
  end

  // Second divider operands.
  sb3_t  sb3_q;
  word_t tav3_q, tbv3_q, al3_q, avm3_q, bvm3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb3_q  <= sb2_q;
      tav3_q <= zext16(sb2_q.t) * avm2_q;
      tbv3_q <= tmt2_q * bvm2_q;
      al3_q  <= zext16(alpha_q) << FracBits;
      avm3_q <= avm2_q;
      bvm3_q <= bvm2_q;
    end
  end

  // Second divider round.
  word_t dl_q0, dr_q0, u0_q0, u1_q0;
  sb3_t  sbq;
  logic  vq_d;

  stbe_div u_div_winl (
    .clk_i, .en_i(en), .num_i(al3_q), .den_i(avm3_q), .quo_o(dl_q0)
  );
  stbe_div u_div_winr (
    .clk_i, .en_i(en), .num_i(al3_q), .den_i(bvm3_q), .quo_o(dr_q0)
  );
  stbe_div u_div_ul (
    .clk_i, .en_i(en), .num_i(tav3_q), .den_i(zext16(alpha_q)), .quo_o(u0_q0)
  );
  stbe_div u_div_ur (
    .clk_i, .en_i(en), .num_i(tbv3_q), .den_i(zext16(alpha_q)), .quo_o(u1_q0)
  );
  stbe_dly #(.Width($bits(sb3_t)), .Depth(DIV_LAT)) u_dly_sb3 (
    .clk_i, .rst_ni, .en_i(en), .d_i(sb3_q), .q_o(sbq)
  );
  stbe_dly #(.Width(1), .Depth(DIV_LAT)) u_dly_v3 (
    .clk_i, .rst_ni, .en_i(en), .d_i(v3_q), .q_o(vq_d)
  );

  assign vq_q = vq_d;

  // Window tests and smoothstep squares.
  logic  inl, inr;
  mode_e mode_d;
  word_t uq [3];
  pass_t p4_q;
  word_t u4_q [3];
  word_t sq4_q [3];
  word_t ud4_q [3];

  always_comb begin
    inl   = slt(zext16(sbq.t), dl_q0);
    inr   = !slt(zext16(sbq.t), zext16(sbq.tf) - dr_q0);
    uq[0] = u0_q0;
    uq[1] = u1_q0;
    uq[2] = sbq.u2;
    if (inl && inr) begin
      mode_d = MODE_BOTH;
    end else if (inl) begin
      mode_d = MODE_LEFT;
    end else if (!inr) begin
      mode_d = MODE_MID;
    end else begin
      mode_d = MODE_RIGHT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q.mode <= mode_d;
      p4_q.av   <= sbq.av;
      p4_q.bv   <= sbq.bv;
      p4_q.l    <= sbq.l;
      p4_q.r    <= sbq.r;
      p4_q.m    <= sbq.m;
      p4_q.mp   <= sbq.mp;
      for (int k = 0; k < 3; k++) begin
        u4_q[k]  <= uq[k];
        sq4_q[k] <= uq[k] * uq[k];
        ud4_q[k] <= uq[k] * (One - uq[k]);
      end
    end
  end

  // Cubes and smoothstep slopes.
  pass_t p5_q;
  word_t h5_q [3];
  word_t cube5_q [3];
  word_t sp5_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q <= p4_q;
      for (int k = 0; k < 3; k++) begin
        h5_q[k]    <= asr(sq4_q[k], FracBits);
        cube5_q[k] <= asr(sq4_q[k], FracBits) * u4_q[k];
        sp5_q[k]   <= asr(ud4_q[k] * word_t'(6), FracBits);
      end
    end
  end

  // Smoothstep values.
  pass_t p6_q;
  word_t s6_q [3];
  word_t sp6_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_q <= p5_q;
      for (int k = 0; k < 3; k++) begin
        s6_q[k]  <= word_t'(3) * h5_q[k] - word_t'(2) * asr(cube5_q[k], FracBits);
        sp6_q[k] <= sp5_q[k];
      end
    end
  end

  // End blend products.
  mode_e mode7_q;
  word_t m7_q, mp7_q, s2_7_q, s2p7_q;
  word_t pl7_q [5];
  word_t pr7_q [5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode7_q  <= p6_q.mode;
      m7_q     <= p6_q.m;
      mp7_q    <= p6_q.mp;
      s2_7_q   <= s6_q[2];
      s2p7_q   <= sp6_q[2];
      pl7_q[0] <= p6_q.l * (One - s6_q[0]);
      pl7_q[1] <= p6_q.m * s6_q[0];
      pl7_q[2] <= (p6_q.m - p6_q.l) * sp6_q[0];
      pl7_q[3] <= sext16(p6_q.av) * (One - s6_q[0]);
      pl7_q[4] <= p6_q.mp * s6_q[0];
      pr7_q[0] <= p6_q.r * (One - s6_q[1]);
      pr7_q[1] <= p6_q.m * s6_q[1];
      pr7_q[2] <= (p6_q.m - p6_q.r) * sp6_q[1];
      pr7_q[3] <= sext16(p6_q.bv) * (One - s6_q[1]);
      pr7_q[4] <= p6_q.mp * s6_q[1];
    end
  end

  // End blends.
  mode_e mode8_q;
  word_t m8_q, mp8_q, s2_8_q, s2p8_q;
  word_t lb8_q, lbp8_q, rb8_q, rbp8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode8_q <= mode7_q;
      m8_q    <= m7_q;
      mp8_q   <= mp7_q;
      s2_8_q  <= s2_7_q;
      s2p8_q  <= s2p7_q;
      lb8_q   <= asr(pl7_q[0] + pl7_q[1], FracBits);
      lbp8_q  <= asr(pl7_q[2] + pl7_q[3] + pl7_q[4], FracBits);
      rb8_q   <= asr(pr7_q[0] + pr7_q[1], FracBits);
      rbp8_q  <= asr(pr7_q[2] + pr7_q[3] + pr7_q[4], FracBits);
    end
  end

  // Cross-blend products.
  mode_e mode9_q;
  word_t m9_q, mp9_q, lb9_q, lbp9_q, rb9_q, rbp9_q;
  word_t c9_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode9_q <= mode8_q;
      m9_q    <= m8_q;
      mp9_q   <= mp8_q;
      lb9_q   <= lb8_q;
      lbp9_q  <= lbp8_q;
      rb9_q   <= rb8_q;
      rbp9_q  <= rbp8_q;
      c9_q[0] <= lb8_q * (One - s2_8_q);
      c9_q[1] <= rb8_q * s2_8_q;
      c9_q[2] <= lbp8_q * (One - s2_8_q);
      c9_q[3] <= lb8_q * s2p8_q;
      c9_q[4] <= rbp8_q * s2_8_q;
      c9_q[5] <= rb8_q * s2p8_q;
    end
  end

  // Final selection and output register.
  word_t posx, velx, pos_sel, vel_sel;
  logic [15:0] pos_q, vel_q;

  always_comb begin
    posx = asr(c9_q[0], FracBits) + asr(c9_q[1], FracBits);
    velx = asr(c9_q[2], FracBits) - asr(c9_q[3], FracBits)
         + asr(c9_q[4], FracBits) + asr(c9_q[5], FracBits);
    case (mode9_q)
      MODE_BOTH: begin
        pos_sel = posx;
        vel_sel = velx;
      end
      MODE_LEFT: begin
        pos_sel = lb9_q;
        vel_sel = lbp9_q;
      end
      MODE_RIGHT: begin
        pos_sel = rb9_q;
        vel_sel = rbp9_q;
      end
      default: begin
        pos_sel = m9_q;
        vel_sel = mp9_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q <= pos_sel[15:0];
      vel_q <= vel_sel[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      v9_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      v0_q   <= in_i.valid;
      v1_q   <= v0_q;
      v2_q   <= vp_q;
      v3_q   <= v2_q;
      v4_q   <= vq_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      v9_q   <= v8_q;
      vout_q <= v9_q;
    end
  end

  assign out_o.valid    = vout_q;
  assign out_o.position = pos_q;
  assign out_o.velocity = vel_q;

endmodule

// ===== hw/rtl/stbe_dly.sv =====
// Enabled shift line that delays a bus by a fixed number of pipeline steps.
// Depends on nothing.
`timescale 1ns / 1ps

module stbe_dly #(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) tap_q[k] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < Depth; k++) tap_q[k] <= tap_q[k-1];
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

// ===== hw/rtl/stbe_div.sv =====
// Pipelined signed 32-bit divider, truncating toward zero, one quotient bit per stage.
// Depends on stbe_pkg; the stages advance only while en_i is high.
`timescale 1ns / 1ps

module stbe_div (
  input  logic            clk_i,
  input  logic            en_i,
  input  stbe_pkg::word_t num_i,
  input  stbe_pkg::word_t den_i,
  output stbe_pkg::word_t quo_o
);
  import stbe_pkg::*;

  localparam int Steps = 32;

  word_t       r_q    [Steps+1];
  word_t       n_q    [Steps+1];
  word_t       d_q    [Steps+1];
  logic        neg_q  [Steps+1];
  logic        zero_q [Steps+1];
  word_t       r_d    [Steps];
  word_t       n_d    [Steps];
  logic [32:0] trial  [Steps];
  word_t       quo_q;

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      trial[k] = {r_q[k], n_q[k][31]} - {1'b0, d_q[k]};
      if (!trial[k][32]) begin
        r_d[k] = trial[k][31:0];
        n_d[k] = {n_q[k][30:0], 1'b1};
      end else begin
        r_d[k] = {r_q[k][30:0], n_q[k][31]};
        n_d[k] = {n_q[k][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= '0;
      n_q[0]    <= num_i[31] ? word_t'(-num_i) : num_i;
      d_q[0]    <= den_i[31] ? word_t'(-den_i) : den_i;
      neg_q[0]  <= num_i[31] ^ den_i[31];
      zero_q[0] <= (den_i == '0);
      for (int k = 0; k < Steps; k++) begin
        r_q[k+1]    <= r_d[k];
        n_q[k+1]    <= n_d[k];
        d_q[k+1]    <= d_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
      end
      if (zero_q[Steps]) begin
        quo_q <= '0;
      end else if (neg_q[Steps]) begin
        quo_q <= word_t'(-n_q[Steps]);
      end else begin
        quo_q <= n_q[Steps];
      end
    end
  end

  assign quo_o = quo_q;

endmodule
